[hw/rtl/dstbr_pkg.sv]
// Shared constants, codes and types of the dual side track bit reader.
package dstbr_pkg;

    // Bytes in each side's track store.
    localparam int TRACK_BYTES = 16384;
    localparam int ADDR_W      = $clog2(TRACK_BYTES);

    // Field widths.
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 14;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 17;
    localparam int LEN_W  = 18;
    localparam int PER_W  = 14;
    localparam int TPU_W  = 8;
    localparam int HIGH_W = 12;
    localparam int LOW_W  = 11;

    // Longest track, in bits: limited by the store and by the length field.
    localparam int LEN_MAX = 131072;
    localparam int LEN_CAP = (TRACK_BYTES * 8 > LEN_MAX) ? LEN_MAX : TRACK_BYTES * 8;

    // MSB-first bit pick within a byte.
    localparam logic [BYTE_W-1:0] BIT_MASK = 8'h80;

    // Tick arithmetic: T = (ticks_per_us * period_ns) / 1000.
    localparam int NS_PER_US   = 1000;
    localparam int PROD_W      = TPU_W + PER_W;
    localparam int TICK_W      = 13;
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 23;
    localparam int RECIP_K     = int'((64'd1 << RECIP_SHIFT) / NS_PER_US);

    // Position rescale divider.
    localparam int DIV_NUM_W = POS_W + LEN_W;
    localparam int DIV_DEN_W = LEN_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    typedef enum logic [CMD_W-1:0] {
        CMD_NEXT  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_GEOM  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TICK = 5'b00010,
        S_FIX  = 5'b00100,
        S_GMUL = 5'b01000,
        S_GDIV = 5'b10000
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } t_div_rsp;

endpackage

[hw/rtl/dstbr_ram.sv]
// Generic single-port RAM with registered read.
module dstbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/dstbr_div.sv]
// Restoring divider, one quotient bit per cycle, for the position rescale.
module dstbr_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dstbr_pkg::t_div_req i_req,
    output dstbr_pkg::t_div_rsp o_rsp
);
    import dstbr_pkg::*;

    logic                 r_run;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_NUM_W-1:0] r_quo;

    logic [DIV_DEN_W:0]   w_trial;
    logic                 w_ge;
    logic [DIV_DEN_W-1:0] n_rem;

    assign w_trial = {r_rem, r_quo[DIV_NUM_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign n_rem   = w_ge ? DIV_DEN_W'(w_trial - {1'b0, r_den}) : DIV_DEN_W'(w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
            end else if (r_run && r_cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_den <= i_req.divisor;
            r_quo <= i_req.dividend;
            r_cnt <= '0;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_NUM_W-2:0], w_ge};
            r_cnt <= r_cnt + DIV_CNT_W'(1);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

[hw/rtl/dual_side_track_bit_reader_top.sv]
// Top level of the dual side track bit reader: command sequencer, track stores, tick math.
//
// Commands enter on start/busy: a transaction is taken at a clock edge with start high
// and busy low. i_cmd selects the command:
//   next bit   - reads the current bit of both heads, advances both (wrapping at each
//                track length), returns the bit of the head on i_head_sel and the pulse
//                high/low durations.
//   write byte - stores i_byte_value at i_byte_index of side i_side.
//   geometry   - sets the track length of i_side (saturated to the store) and the common
//                bit period; that side's position becomes pos * new_len / old_len
//                (0 when old_len is 0).
// Results appear on o_bit_value/o_high_ticks/o_low_ticks for one cycle with o_valid high.
// The receiver cannot stall; every result must be taken. i_cfg_we/i_cfg_wdata write
// ticks_per_us (reset value 80); the user must write it only while idle, the block does not enforce this.
// Next bit: the result strobe follows the store read, the reciprocal multiply (S_TICK) and
// the correction (S_FIX); busy is high in S_TICK and S_FIX, so a new bit is not taken before
// the last one's result. Write byte: busy stays low. Geometry: busy stays low when the old
// length is 0, otherwise busy is high through the product, 35-step restoring divider and write-back.
// Reset clears positions, lengths and period; track stores keep their contents.
module dual_side_track_bit_reader_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [dstbr_pkg::CMD_W-1:0]  i_cmd,
    input  logic                         i_head_sel,
    input  logic                         i_side,
    input  logic [dstbr_pkg::IDX_W-1:0]  i_byte_index,
    input  logic [dstbr_pkg::BYTE_W-1:0] i_byte_value,
    input  logic [dstbr_pkg::LEN_W-1:0]  i_track_bits,
    input  logic [dstbr_pkg::PER_W-1:0]  i_bit_period_ns,
    input  logic                         i_cfg_we,
    input  logic [dstbr_pkg::TPU_W-1:0]  i_cfg_wdata,
    output logic                         o_valid,
    output logic                         o_bit_value,
    output logic [dstbr_pkg::HIGH_W-1:0] o_high_ticks,
    output logic [dstbr_pkg::LOW_W-1:0]  o_low_ticks
);
    import dstbr_pkg::*;

    // Control state
    t_state             r_state;
    logic [POS_W-1:0]   r_pos [2];
    logic [LEN_W-1:0]   r_len [2];
    logic [PER_W-1:0]   r_period;
    logic [TPU_W-1:0]   r_tpu;
    logic               r_valid;

    // Per-transaction payload
    logic               r_head;
    logic [2:0]         r_bitidx;
    logic               r_bitv;
    logic [PROD_W-1:0]  r_prod;
    logic [TICK_W-1:0]  r_q0;
    logic               r_side;
    logic [LEN_W-1:0]   r_len_new;
    logic [DIV_NUM_W-1:0] r_gprod;
    logic               r_bit_out;
    logic [HIGH_W-1:0]  r_high;
    logic [LOW_W-1:0]   r_low;

    t_cmd               w_cmd;
    logic               w_acc;
    logic               w_idx_ok;
    logic [LEN_W-1:0]   w_len_sat;
    logic [POS_W-1:0]   w_side_pos;
    logic [LEN_W-1:0]   w_side_len;
    logic [POS_W-1:0]   w_head_pos;
    logic [POS_W-1:0]   n_pos [2];
    logic               w_we   [2];
    logic [ADDR_W-1:0]  w_addr [2];
    logic [BYTE_W-1:0]  w_rdata [2];
    logic [POS_W-1:0]   w_div_pos;

    // Tick math
    logic [PROD_W+RECIP_W-1:0] w_prodk;
    logic [PROD_W-1:0]  w_q1000;
    logic [PROD_W-1:0]  w_rem;
    logic [TICK_W-1:0]  w_tick;
    logic [TICK_W+1:0]  w_tick3;

    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;

    assign w_cmd      = t_cmd'(i_cmd);
    assign busy       = (r_state != S_IDLE);
    assign w_acc      = start && !busy;
    assign w_idx_ok   = 32'(i_byte_index) < TRACK_BYTES;
    assign w_len_sat  = (32'(i_track_bits) > LEN_CAP) ? LEN_W'(LEN_CAP) : i_track_bits;
    assign w_side_pos = i_side ? r_pos[1] : r_pos[0];
    assign w_side_len = i_side ? r_len[1] : r_len[0];
    assign w_head_pos = i_head_sel ? r_pos[1] : r_pos[0];

    // Track stores: one per side, written by write-byte, read at the head position.
    for (genvar g = 0; g < 2; g++) begin : g_side
        logic [LEN_W-1:0] w_inc;

        assign w_we[g]   = w_acc && (w_cmd == CMD_WRITE) && (i_side == 1'(g)) && w_idx_ok;
        assign w_addr[g] = w_we[g] ? ADDR_W'(i_byte_index) : ADDR_W'(r_pos[g] >> 3);

        // Advance with wrap; a zero length keeps the head at 0.
        assign w_inc    = {1'b0, r_pos[g]} + LEN_W'(1);
        assign n_pos[g] = (w_inc >= r_len[g]) ? '0 : w_inc[POS_W-1:0];

        dstbr_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (TRACK_BYTES)
        ) u_store (
            .i_clk   (i_clk),
            .i_we    (w_we[g]),
            .i_addr  (w_addr[g]),
            .i_wdata (i_byte_value),
            .o_rdata (w_rdata[g])
        );
    end

    // Rescale divider: pos * new_len / old_len.
    assign w_div_req.start    = (r_state == S_GMUL);
    assign w_div_req.dividend = r_gprod;
    assign w_div_req.divisor  = r_side ? r_len[1] : r_len[0];

    dstbr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Quotient is below new_len whenever pos < old_len; guard anyway.
    assign w_div_pos = (w_div_rsp.quot >= DIV_NUM_W'(r_len_new)) ? '0
                                                                 : w_div_rsp.quot[POS_W-1:0];

    // Divide by 1000: reciprocal estimate is low by at most one, fixed by one compare.
    assign w_prodk = (PROD_W+RECIP_W)'(r_prod) * (PROD_W+RECIP_W)'(RECIP_K);
    assign w_q1000 = PROD_W'(r_q0) * PROD_W'(NS_PER_US);
    assign w_rem   = r_prod - w_q1000;
    assign w_tick  = r_q0 + TICK_W'(w_rem >= PROD_W'(NS_PER_US));
    assign w_tick3 = {1'b0, w_tick, 1'b0} + {2'b00, w_tick};

    // Sequencer and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos[0] <= '0;
            r_pos[1] <= '0;
            r_len[0] <= '0;
            r_len[1] <= '0;
            r_period <= '0;
            r_tpu    <= TPU_W'(80);
            r_valid  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_tpu <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        unique case (w_cmd)
                            CMD_NEXT: begin
                                r_pos[0] <= n_pos[0];
                                r_pos[1] <= n_pos[1];
                                r_state  <= S_TICK;
                            end
                            CMD_GEOM: begin
                                r_period <= i_bit_period_ns;
                                if (w_side_len == '0) begin
                                    r_pos[i_side] <= '0;
                                    r_len[i_side] <= w_len_sat;
                                end else begin
                                    r_state <= S_GMUL;
                                end
                            end
                            CMD_WRITE, CMD_NONE: begin
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_TICK: r_state <= S_FIX;
                S_FIX: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_GMUL: r_state <= S_GDIV;
                S_GDIV: begin
                    if (w_div_rsp.done) begin
                        r_pos[r_side] <= w_div_pos;
                        r_len[r_side] <= r_len_new;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_head    <= i_head_sel;
            r_bitidx  <= w_head_pos[2:0];
            r_prod    <= PROD_W'(r_tpu) * PROD_W'(r_period);
            r_side    <= i_side;
            r_len_new <= w_len_sat;
            r_gprod   <= DIV_NUM_W'(w_side_pos) * DIV_NUM_W'(w_len_sat);
        end
        if (r_state == S_TICK) begin
            r_bitv <= |(w_rdata[r_head] & (BIT_MASK >> r_bitidx));
            r_q0   <= TICK_W'(w_prodk >> RECIP_SHIFT);
        end
        if (r_state == S_FIX) begin
            r_bit_out <= r_bitv;
            r_high    <= w_tick3[HIGH_W+1:2];
            r_low     <= w_tick[TICK_W-1:2];
        end
    end

    assign o_valid      = r_valid;
    assign o_bit_value  = r_bit_out;
    assign o_high_ticks = r_high;
    assign o_low_ticks  = r_low;

    // Checks
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == CMD_NEXT) |-> ##3 o_valid)
        else $error("next-bit result missing");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_FIX))
        else $error("result strobe without correction stage");

    a_pos0_in_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos[0] == '0) || ({1'b0, r_pos[0]} < r_len[0]))
        else $error("side 0 position past track end");

    a_pos1_in_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos[1] == '0) || ({1'b0, r_pos[1]} < r_len[1]))
        else $error("side 1 position past track end");

endmodule
